// File: sv/updq_pkg.sv
`timescale 1ns / 1ps
package updq_pkg;

   // default sizes
   localparam int DEF_BINDINGS    = 16;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_MAX_PAYLOAD = 1024;

   // depth of the queue between classifier and executor
   localparam int CMDQ_DEPTH = 2;

   // fixed result field widths
   localparam int IDX_OUT_W = 4;
   localparam int LEN_OUT_W = 11;

   // request kinds
   localparam logic [1:0] KIND_BIND   = 2'd0;
   localparam logic [1:0] KIND_UNBIND = 2'd1;
   localparam logic [1:0] KIND_FRAME  = 2'd2;
   localparam logic [1:0] KIND_RECV   = 2'd3;

   // result status codes
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_ALREADY    = 4'd1;
   localparam logic [3:0] ST_NOT_BOUND  = 4'd2;
   localparam logic [3:0] ST_TABLE_FULL = 4'd3;
   localparam logic [3:0] ST_QUEUE_FULL = 4'd4;
   localparam logic [3:0] ST_NOT_UDP    = 4'd5;
   localparam logic [3:0] ST_DROPPED    = 4'd6;
   localparam logic [3:0] ST_ARP        = 4'd7;
   localparam logic [3:0] ST_EMPTY      = 4'd8;

   // protocol constants
   localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
   localparam logic [15:0] ETHER_TYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETHER_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] MIN_ARP_LEN     = 16'd42;  // eth header + arp body
   localparam logic [15:0] MIN_IP_LEN      = 16'd34;  // eth header + ip header
   localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;

   // internal operations handed from classifier to executor
   localparam logic [2:0] OP_DIRECT = 3'd0;
   localparam logic [2:0] OP_BIND   = 3'd1;
   localparam logic [2:0] OP_UNBIND = 3'd2;
   localparam logic [2:0] OP_ENQ    = 3'd3;
   localparam logic [2:0] OP_DEQ    = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] port;
      logic [15:0] frame_len;
      logic [15:0] ethertype;
      logic [7:0]  ip_proto;
      logic [15:0] dest_port;
      logic [15:0] udp_length;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [15:0] max_len;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  binding_index;
      logic [3:0]  queue_slot;
      logic [31:0] out_source_ip;
      logic [15:0] out_source_port;
      logic [10:0] out_length;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  status;   // used by direct results only
      logic [15:0] port;     // lookup key
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [15:0] len;      // clamped payload length
      logic [15:0] max_len;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cmdq_stat_type;

endpackage

// File: sv/updq_front.sv
`timescale 1ns / 1ps
module updq_front
   import updq_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  req_type req,
   output cmd_type cmd
);

   logic [15:0] pl_raw;
   logic [15:0] pl;

   // payload length: udp length minus header, clamped
   always_comb begin
      pl_raw = (req.udp_length >= UDP_HDR_BYTES) ? (req.udp_length - UDP_HDR_BYTES) : 16'd0;
      pl     = (pl_raw > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD) : pl_raw;
   end

   always_comb begin
      cmd.op          = OP_DIRECT;
      cmd.status      = ST_OK;
      cmd.port        = req.port;
      cmd.source_ip   = req.source_ip;
      cmd.source_port = req.source_port;
      cmd.len         = pl;
      cmd.max_len     = req.max_len;
      case (req.kind)
         KIND_BIND:   cmd.op = OP_BIND;
         KIND_UNBIND: cmd.op = OP_UNBIND;
         KIND_FRAME: begin
            if (req.frame_len >= MIN_ARP_LEN && req.ethertype == ETHER_TYPE_ARP) begin
               cmd.status = ST_ARP;
            end else if (!(req.frame_len >= MIN_IP_LEN && req.ethertype == ETHER_TYPE_IPV4)) begin
               cmd.status = ST_DROPPED;
            end else if (req.ip_proto != IP_PROTO_UDP) begin
               cmd.status = ST_NOT_UDP;
            end else begin
               cmd.op   = OP_ENQ;
               cmd.port = req.dest_port;
            end
         end
         KIND_RECV:   cmd.op = OP_DEQ;
         default:     cmd.op = OP_DIRECT;
      endcase
   end

endmodule

// File: sv/updq_cmd_queue.sv
`timescale 1ns / 1ps
module updq_cmd_queue
   import updq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_cmd,
   input  logic          pop,
   output cmd_type       head_cmd,
   output cmdq_stat_type stat
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign stat.full  = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/updq_back.sv
`timescale 1ns / 1ps
module updq_back
   import updq_pkg::*;
#(
   parameter int BINDINGS    = DEF_BINDINGS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int BIDX_W = (BINDINGS > 1) ? $clog2(BINDINGS) : 1;
   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int ENT_W  = 32 + 16 + LEN_W;
   localparam int DEPTH  = BINDINGS * QUEUE_DEPTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   // binding table and per-slot ring pointers
   logic              valid_ff [BINDINGS];
   logic              valid_in [BINDINGS];
   logic [15:0]       port_ff  [BINDINGS];
   logic [15:0]       port_in  [BINDINGS];
   logic [QIDX_W-1:0] head_ff  [BINDINGS];
   logic [QIDX_W-1:0] head_in  [BINDINGS];
   logic [QIDX_W-1:0] tail_ff  [BINDINGS];
   logic [QIDX_W-1:0] tail_in  [BINDINGS];
   logic [CNT_W-1:0]  count_ff [BINDINGS];
   logic [CNT_W-1:0]  count_in [BINDINGS];

   // descriptor memory
   logic [ENT_W-1:0]  mem_ff [DEPTH];
   logic [ENT_W-1:0]  rd_data_ff;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [ENT_W-1:0]  mem_wdata;

   logic state_ff, state_in;
   logic exec;
   logic done;

   // result of the execute step, held for the finish step
   logic [3:0]        pend_status_ff, pend_status_in;
   logic [BIDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [QIDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [15:0]       pend_len_ff, pend_len_in;
   logic              pend_deq_ff, pend_deq_in;
   logic [15:0]       pend_max_ff, pend_max_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // port match and free slot search
   logic              hit;
   logic [BIDX_W-1:0] hit_idx;
   logic              any_free;
   logic [BIDX_W-1:0] free_idx;
   logic [QIDX_W-1:0] slot_sel;
   logic [BIDX_W-1:0] idx_sel;

   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      any_free = 1'b0;
      free_idx = '0;
      for (int i = 0; i < BINDINGS; i++) begin
         if (valid_ff[i] && port_ff[i] == cmd.port) begin
            hit     = 1'b1;
            hit_idx = hit_idx | BIDX_W'(i);
         end
      end
      for (int i = BINDINGS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = BIDX_W'(i);
         end
      end
   end

   function automatic logic [QIDX_W-1:0] ring_next(input logic [QIDX_W-1:0] p);
      ring_next = (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign exec    = (state_ff == ST_IDLE) && cmd_valid;
   assign done    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop = exec;

   assign slot_sel  = (cmd.op == OP_DEQ) ? head_ff[hit_idx] : tail_ff[hit_idx];
   assign idx_sel   = hit_idx;
   assign mem_addr  = ADDR_W'(ADDR_W'(idx_sel) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot_sel);
   assign mem_wdata = {cmd.source_ip, cmd.source_port, LEN_W'(cmd.len)};

   // execute step: table update and descriptor access
   always_comb begin
      valid_in       = valid_ff;
      port_in        = port_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      pend_status_in = pend_status_ff;
      pend_idx_in    = pend_idx_ff;
      pend_slot_in   = pend_slot_ff;
      pend_len_in    = pend_len_ff;
      pend_deq_in    = pend_deq_ff;
      pend_max_in    = pend_max_ff;
      if (exec) begin
         pend_status_in = ST_OK;
         pend_idx_in    = '0;
         pend_slot_in   = '0;
         pend_len_in    = '0;
         pend_deq_in    = 1'b0;
         pend_max_in    = cmd.max_len;
         case (cmd.op)
            OP_BIND: begin
               if (hit) begin
                  pend_status_in = ST_ALREADY;
                  pend_idx_in    = hit_idx;
               end else if (any_free) begin
                  pend_idx_in        = free_idx;
                  valid_in[free_idx] = 1'b1;
                  port_in[free_idx]  = cmd.port;
                  head_in[free_idx]  = '0;
                  tail_in[free_idx]  = '0;
                  count_in[free_idx] = '0;
               end else begin
                  pend_status_in = ST_TABLE_FULL;
               end
            end
            OP_UNBIND: begin
               if (!hit) begin
                  pend_status_in = ST_NOT_BOUND;
               end else begin
                  pend_idx_in       = hit_idx;
                  valid_in[hit_idx] = 1'b0;
                  port_in[hit_idx]  = '0;
                  head_in[hit_idx]  = '0;
                  tail_in[hit_idx]  = '0;
                  count_in[hit_idx] = '0;
               end
            end
            OP_ENQ: begin
               if (!hit) begin
                  pend_status_in = ST_NOT_BOUND;
               end else if (count_ff[hit_idx] == CNT_W'(QUEUE_DEPTH)) begin
                  pend_status_in = ST_QUEUE_FULL;
                  pend_idx_in    = hit_idx;
               end else begin
                  pend_idx_in       = hit_idx;
                  pend_slot_in      = slot_sel;
                  pend_len_in       = cmd.len;
                  mem_we            = 1'b1;
                  tail_in[hit_idx]  = ring_next(slot_sel);
                  count_in[hit_idx] = count_ff[hit_idx] + 1'b1;
               end
            end
            OP_DEQ: begin
               if (!hit) begin
                  pend_status_in = ST_NOT_BOUND;
               end else if (count_ff[hit_idx] == '0) begin
                  pend_status_in = ST_EMPTY;
                  pend_idx_in    = hit_idx;
               end else begin
                  pend_idx_in       = hit_idx;
                  pend_slot_in      = slot_sel;
                  pend_deq_in       = 1'b1;
                  mem_re            = 1'b1;
                  head_in[hit_idx]  = ring_next(slot_sel);
                  count_in[hit_idx] = count_ff[hit_idx] - 1'b1;
               end
            end
            default: begin
               pend_status_in = cmd.status;
            end
         endcase
      end
   end

   // finish step: clip dequeued length and load the output register
   logic [15:0] rd_len;
   logic [15:0] clip_len;
   logic [BIDX_W+IDX_OUT_W-1:0] idx_ext;
   logic [QIDX_W+IDX_OUT_W-1:0] slot_ext;

   always_comb begin
      rd_len   = 16'(rd_data_ff[LEN_W-1:0]);
      clip_len = (rd_len > pend_max_ff) ? pend_max_ff : rd_len;
      idx_ext  = {{IDX_OUT_W{1'b0}}, pend_idx_ff};
      slot_ext = {{IDX_OUT_W{1'b0}}, pend_slot_ff};

      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in           = 1'b1;
         rsp_in.status          = pend_status_ff;
         rsp_in.binding_index   = idx_ext[IDX_OUT_W-1:0];
         rsp_in.queue_slot      = slot_ext[IDX_OUT_W-1:0];
         if (pend_deq_ff) begin
            rsp_in.out_source_ip   = rd_data_ff[ENT_W-1 -: 32];
            rsp_in.out_source_port = rd_data_ff[LEN_W +: 16];
            rsp_in.out_length      = clip_len[LEN_OUT_W-1:0];
         end else begin
            rsp_in.out_source_ip   = '0;
            rsp_in.out_source_port = '0;
            rsp_in.out_length      = pend_len_ff[LEN_OUT_W-1:0];
         end
      end

      state_in = state_ff;
      if (exec) begin
         state_in = ST_FINISH;
      end else if (done) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BINDINGS; i++) begin
            valid_ff[i] <= 1'b0;
            port_ff[i]  <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         port_ff      <= port_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_idx_ff    <= pend_idx_in;
      pend_slot_ff   <= pend_slot_in;
      pend_len_ff    <= pend_len_in;
      pend_deq_ff    <= pend_deq_in;
      pend_max_ff    <= pend_max_in;
      rsp_ff         <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/udp_port_demux_queues_unit.sv
`timescale 1ns / 1ps
// UDP port demultiplexer with one descriptor ring per bound port. Each request
// transfer gives exactly one response transfer, in request order. A bind takes
// the lowest free binding slot (status 3 when the table is full, status 1 with
// the existing slot when the port is already bound) and empties its ring; an
// unbind frees the slot. A received frame is classified by length and type:
// arp is flagged, short or foreign frames are dropped, non-udp ip is rejected,
// and a udp frame for a bound port with room is stored as a descriptor
// (source ip, source port, payload length clamped to MAX_PAYLOAD). A receive
// request pops one descriptor with the length clipped to max_len, or answers
// status 8 when the ring is empty. binding_index and queue_slot address an
// external payload buffer. A classifier takes requests into a two-entry
// command queue; the executor then works through two steps per command, one
// for the port match, table update and descriptor memory access, one to form
// the response from the registered memory read, and takes the next command
// only once the last response is loaded into the response register. There is
// no clearing pass after reset: requests are taken once reset is released.
module udp_port_demux_queues_unit
   import updq_pkg::*;
#(
   parameter int BINDINGS    = DEF_BINDINGS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type       front_cmd;   // classified request
   cmd_type       queue_cmd;   // oldest queued command
   cmdq_stat_type queue_stat;
   logic          queue_push;
   logic          queue_pop;

   // front end: stateless classification of the incoming transfer
   updq_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   // a request is taken whenever the command queue has room
   assign req_ready  = !queue_stat.full;
   assign queue_push = req_valid && req_ready;

   updq_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (front_cmd),
      .pop      (queue_pop),
      .head_cmd (queue_cmd),
      .stat     (queue_stat)
   );

   // back end: binding table, ring pointers, descriptor memory, response register
   updq_back #(
      .BINDINGS    (BINDINGS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (queue_cmd),
      .cmd_valid (!queue_stat.empty),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import updq_pkg::*;

   // sizes follow the block's defaults
   localparam int NSLOT = DEF_BINDINGS;
   localparam int NDESC = DEF_QUEUE_DEPTH;
   localparam int POOL_SIZE = 20;            // a few more ports than slots, so the table fills
   localparam int PHASE_ITEMS = 150;
   localparam int PHASES = 4;
   localparam int MAX_GAP = 18;
   localparam int DRAIN_CYCLES = 20;         // quiet window after the last owed response
   // worst quiet stretch: sender gap + receiver stall + executor steps, with margin
   localparam int STALL_LIMIT = 1000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   udp_port_demux_queues_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // one directed row: the request, and a hand-written response where it is obvious
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   // shadow of the port table and the per-slot descriptor rings
   logic        slot_used [NSLOT];
   logic [15:0] slot_port [NSLOT];
   logic [3:0]  ring_head [NSLOT];
   logic [3:0]  ring_tail [NSLOT];
   logic [4:0]  ring_fill [NSLOT];
   logic [31:0] desc_ip   [NSLOT][NDESC];
   logic [15:0] desc_port [NSLOT][NDESC];
   logic [10:0] desc_len  [NSLOT][NDESC];

   rsp_type     awaited_rsp [$];   // responses owed, in request order
   int          fail_count = 0;
   int          stall_cycles = 0;
   bit          tx_steady = 1'b0;  // sender back to back
   bit          rx_steady = 1'b0;  // receiver always ready
   logic [15:0] port_pool [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic req_type mk_req(logic [1:0] kind, logic [15:0] port, flen, etype,
                                      logic [7:0] proto, logic [15:0] dport, ulen,
                                      logic [31:0] sip, logic [15:0] sport, maxl);
      req_type r;
      r.kind = kind;
      r.port = port;
      r.frame_len = flen;
      r.ethertype = etype;
      r.ip_proto = proto;
      r.dest_port = dport;
      r.udp_length = ulen;
      r.source_ip = sip;
      r.source_port = sport;
      r.max_len = maxl;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [3:0] st, int bi, int qs, logic [31:0] ip,
                                      logic [15:0] sp, logic [10:0] len);
      rsp_type r;
      r.status = st;
      r.binding_index = 4'(bi);
      r.queue_slot = 4'(qs);
      r.out_source_ip = ip;
      r.out_source_port = sp;
      r.out_length = len;
      return r;
   endfunction

   function automatic int slot_of_port(logic [15:0] p);
      for (int k = 0; k < NSLOT; k++)
         if (slot_used[k] && slot_port[k] == p) return k;
      return -1;
   endfunction

   // advances the shadow table by one request and returns the response it owes
   function automatic rsp_type predict_demux_result(req_type r);
      int          i;
      int          s;
      logic [15:0] pl;
      logic [15:0] clip;
      case (r.kind)
         KIND_BIND: begin
            i = slot_of_port(r.port);
            if (i >= 0) return mk_rsp(ST_ALREADY, i, 0, 0, 0, 0);
            // lowest free slot wins, and its ring starts empty
            for (int k = 0; k < NSLOT; k++) begin
               if (!slot_used[k]) begin
                  slot_used[k] = 1'b1;
                  slot_port[k] = r.port;
                  ring_head[k] = '0;
                  ring_tail[k] = '0;
                  ring_fill[k] = '0;
                  return mk_rsp(ST_OK, k, 0, 0, 0, 0);
               end
            end
            return mk_rsp(ST_TABLE_FULL, 0, 0, 0, 0, 0);
         end
         KIND_UNBIND: begin
            i = slot_of_port(r.port);
            if (i < 0) return mk_rsp(ST_NOT_BOUND, 0, 0, 0, 0, 0);
            slot_used[i] = 1'b0;
            slot_port[i] = '0;
            ring_head[i] = '0;
            ring_tail[i] = '0;
            ring_fill[i] = '0;
            return mk_rsp(ST_OK, i, 0, 0, 0, 0);
         end
         KIND_FRAME: begin
            // arp wins over the ip check once it is long enough
            if (r.frame_len >= MIN_ARP_LEN && r.ethertype == ETHER_TYPE_ARP)
               return mk_rsp(ST_ARP, 0, 0, 0, 0, 0);
            if (!(r.frame_len >= MIN_IP_LEN && r.ethertype == ETHER_TYPE_IPV4))
               return mk_rsp(ST_DROPPED, 0, 0, 0, 0, 0);
            if (r.ip_proto != IP_PROTO_UDP) return mk_rsp(ST_NOT_UDP, 0, 0, 0, 0, 0);
            i = slot_of_port(r.dest_port);
            if (i < 0) return mk_rsp(ST_NOT_BOUND, 0, 0, 0, 0, 0);
            if (ring_fill[i] >= NDESC) return mk_rsp(ST_QUEUE_FULL, i, 0, 0, 0, 0);
            // payload length: udp length less its header, clamped to the buffer size
            pl = (r.udp_length >= UDP_HDR_BYTES) ? r.udp_length - UDP_HDR_BYTES : 16'd0;
            if (pl > 16'(DEF_MAX_PAYLOAD)) pl = 16'(DEF_MAX_PAYLOAD);
            s = int'(ring_tail[i]);
            desc_ip[i][s] = r.source_ip;
            desc_port[i][s] = r.source_port;
            desc_len[i][s] = pl[10:0];
            ring_tail[i] = 4'((s + 1) % NDESC);
            ring_fill[i] = ring_fill[i] + 5'd1;
            return mk_rsp(ST_OK, i, s, 0, 0, pl[10:0]);
         end
         default: begin
            i = slot_of_port(r.port);
            if (i < 0) return mk_rsp(ST_NOT_BOUND, 0, 0, 0, 0, 0);
            if (ring_fill[i] == 0) return mk_rsp(ST_EMPTY, i, 0, 0, 0, 0);
            s = int'(ring_head[i]);
            clip = ({5'd0, desc_len[i][s]} > r.max_len) ? r.max_len : {5'd0, desc_len[i][s]};
            ring_head[i] = 4'((s + 1) % NDESC);
            ring_fill[i] = ring_fill[i] - 5'd1;
            return mk_rsp(ST_OK, i, s, desc_ip[i][s], desc_port[i][s], clip[10:0]);
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // random request; the phase sets the mix, which moves the block through
   // table-full, queue-full and drain-to-empty in turn
   function automatic req_type random_item(int phase);
      req_type r;
      int      roll;
      int      wb;
      int      wu;
      int      wf;
      int      wr;
      // every field starts random, so unused fields still toggle every bit
      r = mk_req(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
      case (phase)
         0:       begin wb = 30; wu = 5;  wf = 35; wr = 20; end
         1:       begin wb = 5;  wu = 5;  wf = 65; wr = 15; end
         2:       begin wb = 5;  wu = 10; wf = 20; wr = 55; end
         default: begin wb = 20; wu = 15; wf = 35; wr = 20; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < wb) begin
         r.kind = KIND_BIND;
         r.port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < wb + wu) begin
         r.kind = KIND_UNBIND;
         r.port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < wb + wu + wf) begin
         // mostly clean udp frames aimed at ports we use
         r.kind = KIND_FRAME;
         r.ethertype = ETHER_TYPE_IPV4;
         r.ip_proto = IP_PROTO_UDP;
         r.frame_len = 16'($urandom_range(MIN_IP_LEN, 65535));
         if ($urandom_range(0, 9) != 0) r.dest_port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 1) == 1) r.udp_length = 16'($urandom_range(0, 1100));
         // a fifth are broken: short, arp, or the wrong protocol
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
               0:       r.ethertype = ETHER_TYPE_ARP;
               1:       r.ethertype = ETHER_TYPE_IPV4;
               default: r.ethertype = 16'($urandom);
            endcase
            r.frame_len = 16'($urandom_range(0, 60));
            r.ip_proto = 8'($urandom);
         end
      end else if (roll < wb + wu + wf + wr) begin
         r.kind = KIND_RECV;
         r.port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 1) == 1) r.max_len = 16'($urandom_range(0, 1100));
      end
      // the rest stays pure noise
      return r;
   endfunction

   // one request transfer; the response it owes is queued at acceptance
   task automatic send_request(req_type r, bit typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = predict_demux_result(r);
      awaited_rsp.push_back(typed ? want : predicted);
   endtask

   // response side: random stalls, each transfer checked against the oldest owed response
   initial begin
      rsp_type want;
      int      gap;
      rsp_ready = 1'b0;
      forever begin
         gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (awaited_rsp.size() == 0) begin
            $error("response transfer with nothing outstanding");
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("binding_index", want.binding_index, rsp_data.binding_index);
            check_field("queue_slot", want.queue_slot, rsp_data.queue_slot);
            check_field("out_source_ip", want.out_source_ip, rsp_data.out_source_ip);
            check_field("out_source_port", want.out_source_port, rsp_data.out_source_port);
            check_field("out_length", want.out_length, rsp_data.out_length);
         end
      end
   end

   // watchdog: too long without any transfer on either side
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("FAIL udp_port_demux_queues_unit");
      $finish;
   end

   initial begin
      stim_row_type directed_rows [$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      for (int k = 0; k < NSLOT; k++) begin
         slot_used[k] = 1'b0;
         slot_port[k] = '0;
         ring_head[k] = '0;
         ring_tail[k] = '0;
         ring_fill[k] = '0;
      end
      // port pool: both extremes plus random ports
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hFFFF;
      for (int k = 2; k < POOL_SIZE; k++) port_pool[k] = 16'($urandom);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every classification path, both port extremes, length clamp and clip
      directed_rows = '{
         // fresh table: nothing bound
         '{mk_req(KIND_RECV, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_NOT_BOUND, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_UNBIND, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_NOT_BOUND, 0, 0, 0, 0, 0)},
         // frame classification at the length limits
         '{mk_req(KIND_FRAME, 0, MIN_ARP_LEN, ETHER_TYPE_ARP, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_ARP, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_FRAME, 0, MIN_ARP_LEN - 16'd1, ETHER_TYPE_ARP, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_DROPPED, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_FRAME, 0, MIN_IP_LEN - 16'd1, ETHER_TYPE_IPV4, IP_PROTO_UDP,
                  0, 0, 0, 0, 0), 1'b1, mk_rsp(ST_DROPPED, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_FRAME, 0, 16'hFFFF, 16'hFFFF, IP_PROTO_UDP, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_DROPPED, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_FRAME, 0, MIN_IP_LEN, ETHER_TYPE_IPV4, 8'd6, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_NOT_UDP, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_FRAME, 0, 16'hFFFF, ETHER_TYPE_IPV4, 8'hFF, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_NOT_UDP, 0, 0, 0, 0, 0)},
         // udp for a port nobody holds
         '{mk_req(KIND_FRAME, 0, MIN_IP_LEN, ETHER_TYPE_IPV4, IP_PROTO_UDP, 0, 16'd100,
                  0, 0, 0), 1'b1, mk_rsp(ST_NOT_BOUND, 0, 0, 0, 0, 0)},
         // bind both extremes, then a double bind
         '{mk_req(KIND_BIND, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_OK, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_BIND, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_OK, 1, 0, 0, 0, 0)},
         '{mk_req(KIND_BIND, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_ALREADY, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_RECV, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
           mk_rsp(ST_EMPTY, 0, 0, 0, 0, 0)},
         // udp length below the header, then far above the payload limit
         '{mk_req(KIND_FRAME, 0, MIN_IP_LEN, ETHER_TYPE_IPV4, IP_PROTO_UDP, 16'h0000,
                  16'h0000, 32'h0, 16'h0, 0), 1'b1, mk_rsp(ST_OK, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_FRAME, 0, 16'hFFFF, ETHER_TYPE_IPV4, IP_PROTO_UDP, 16'h0000,
                  16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 0), 1'b1,
           mk_rsp(ST_OK, 0, 1, 0, 0, 11'd1024)},
         '{mk_req(KIND_FRAME, 0, 16'd60, ETHER_TYPE_IPV4, IP_PROTO_UDP, 16'h0000,
                  UDP_HDR_BYTES, 32'hC0A8_0001, 16'd53, 0), 1'b0, '0},
         '{mk_req(KIND_FRAME, 0, 16'd1500, ETHER_TYPE_IPV4, IP_PROTO_UDP, 16'hFFFF,
                  16'd1032, 32'h0A00_0002, 16'd4000, 0), 1'b0, '0},
         '{mk_req(KIND_FRAME, 0, 16'd1500, ETHER_TYPE_IPV4, IP_PROTO_UDP, 16'hFFFF,
                  16'd1031, 32'h8000_0000, 16'h8000, 0), 1'b0, '0},
         // dequeue with no clip, clip to zero, partial clip
         '{mk_req(KIND_RECV, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0, '0},
         '{mk_req(KIND_RECV, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b0, '0},
         '{mk_req(KIND_RECV, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 16'd1000), 1'b0, '0},
         // unbind frees slot 1, which the next bind reuses
         '{mk_req(KIND_UNBIND, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_OK, 1, 0, 0, 0, 0)},
         '{mk_req(KIND_RECV, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
           mk_rsp(ST_NOT_BOUND, 0, 0, 0, 0, 0)},
         '{mk_req(KIND_BIND, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(ST_OK, 1, 0, 0, 0, 0)}
      };
      foreach (directed_rows[n])
         send_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);

      // random phases; one with the sender back to back, one with the receiver never stalling
      for (int phase = 0; phase < PHASES; phase++) begin
         tx_steady = (phase == 1);
         rx_steady = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_item(phase), 1'b0, '0);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then a short quiet window to catch stray responses
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS udp_port_demux_queues_unit");
      end else begin
         $display("FAIL udp_port_demux_queues_unit");
      end
      $finish;
   end

endmodule
